// ----- sv/bpc_pkg.sv -----
// Shared types, constants and helpers of the barometer compensation block.
package bpc_pkg;

	localparam int unsigned DIV_W = 32;
	localparam int unsigned FRONT_STAGES = 10;
	localparam int unsigned BACK_STAGES = 6;
	localparam int unsigned LATENCY = FRONT_STAGES + DIV_W + BACK_STAGES;

	localparam logic [31:0] T_OFFSET = 32'd64000;
	localparam logic [31:0] ADC_FULL = 32'd1048576;
	localparam logic [31:0] P_SCALE = 32'd3125;
	localparam logic [31:0] P1_BIAS = 32'd32768;
	localparam logic [32:0] MBAR_HALF = 33'd50;
	// ceil(2^36 / 25): the pascal value is divided by 4 first, then by 25.
	localparam logic [31:0] RECIP_25 = 32'd2748779070;
	localparam int unsigned RECIP_SHIFT = 36;

	localparam logic [15:0] WIN_LO_RESET = 16'd700;
	localparam logic [15:0] WIN_HI_RESET = 16'd1400;

	typedef enum logic [2:0] {
		REG_CAL_TEMP = 3'd0,
		REG_CAL_P12  = 3'd1,
		REG_CAL_P34  = 3'd2,
		REG_CAL_P56  = 3'd3,
		REG_CAL_P78  = 3'd4,
		REG_CAL_P9   = 3'd5,
		REG_WIN_LO   = 3'd6,
		REG_WIN_HI   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_ZERO  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p5;
		logic [31:0] p6;
		logic [31:0] p7;
		logic [31:0] p8;
		logic [31:0] p9;
	} cal_t;

	// Per-item values that ride alongside the divider.
	typedef struct packed {
		logic [15:0] temp;
		logic        zero;
		logic        dbl;
	} side_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

endpackage

// ----- sv/bpc_cfg_regs.sv -----
// Calibration and window registers with their coefficient unpacking.
module bpc_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [47:0]          cfg_data,
	output bpc_pkg::cal_t        cal,
	output logic [15:0]          win_lo,
	output logic [15:0]          win_hi
);
	import bpc_pkg::*;

	logic [47:0] cal_temp_q;
	logic [31:0] p12_q, p34_q, p56_q, p78_q;
	logic [15:0] p9_q, win_lo_q, win_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q <= '0;
			p12_q <= '0;
			p34_q <= '0;
			p56_q <= '0;
			p78_q <= '0;
			p9_q <= '0;
			win_lo_q <= WIN_LO_RESET;
			win_hi_q <= WIN_HI_RESET;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_CAL_TEMP: cal_temp_q <= cfg_data;
				REG_CAL_P12: p12_q <= cfg_data[31:0];
				REG_CAL_P34: p34_q <= cfg_data[31:0];
				REG_CAL_P56: p56_q <= cfg_data[31:0];
				REG_CAL_P78: p78_q <= cfg_data[31:0];
				REG_CAL_P9: p9_q <= cfg_data[15:0];
				REG_WIN_LO: win_lo_q <= cfg_data[15:0];
				REG_WIN_HI: win_hi_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1 = {16'd0, cal_temp_q[47:32]};
		cal.t2 = sx16(cal_temp_q[31:16]);
		cal.t3 = sx16(cal_temp_q[15:0]);
		cal.p1 = {16'd0, p12_q[31:16]};
		cal.p2 = sx16(p12_q[15:0]);
		cal.p3 = sx16(p34_q[31:16]);
		cal.p4 = sx16(p34_q[15:0]);
		cal.p5 = sx16(p56_q[31:16]);
		cal.p6 = sx16(p56_q[15:0]);
		cal.p7 = sx16(p78_q[31:16]);
		cal.p8 = sx16(p78_q[15:0]);
		cal.p9 = sx16(p9_q);
	end

	assign win_lo = win_lo_q;
	assign win_hi = win_hi_q;

endmodule

// ----- sv/bpc_front.sv -----
// Temperature fine value and pressure dividend/divisor pipeline.
module bpc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [19:0]          adc_press,
	input  logic [19:0]          adc_temp,
	input  bpc_pkg::cal_t        cal,
	output logic                 out_valid,
	output logic [31:0]          dividend,
	output logic [31:0]          divisor,
	output bpc_pkg::side_t       side
);
	import bpc_pkg::*;

	logic [FRONT_STAGES:1] v_q;
	logic [19:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8;
	logic [31:0] a_s1, b_s1, m1_s2, bb_s2, v1t_s3, m2_s3, tf_s4;
	logic [31:0] pv1_s5, q_s5, sq_s6, m5_s6, m2p_s6, m6_s7, m3_s7, m5_s7, m2p_s7;
	logic [31:0] v2_s8, t_s8, m7_s9, n_s9, dv_s10, pm_s10;
	logic [15:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic [31:0] tf5, tcw, pv1;
	logic [15:0] tsat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[FRONT_STAGES-1:1], in_valid};
		end
	end

	// Temperature scaling with saturation to a signed 16-bit value, plus the offset pressure term pv1.
	always_comb begin
		tf5 = (tf_s4 << 2) + tf_s4 + 32'd128;
		tcw = asr(tf5, 8);
		if (!tcw[31] && tcw[30:15] != '0) begin
			tsat = 16'h7fff;
		end else if (tcw[31] && tcw[30:15] != '1) begin
			tsat = 16'h8000;
		end else begin
			tsat = tcw[15:0];
		end
		pv1 = asr(tf_s4, 1) - T_OFFSET;
	end

	always_ff @(posedge clk) begin
		a_s1 <= {15'd0, adc_temp[19:3]} - (cal.t1 << 1);
		b_s1 <= {16'd0, adc_temp[19:4]} - cal.t1;
		ap_s1 <= adc_press;

		m1_s2 <= a_s1 * cal.t2;
		bb_s2 <= b_s1 * b_s1;
		ap_s2 <= ap_s1;

		v1t_s3 <= asr(m1_s2, 11);
		m2_s3 <= asr(bb_s2, 12) * cal.t3;
		ap_s3 <= ap_s2;

		tf_s4 <= v1t_s3 + asr(m2_s3, 14);
		ap_s4 <= ap_s3;

		temp_s5 <= tsat;
		pv1_s5 <= pv1;
		q_s5 <= asr(pv1, 2);
		ap_s5 <= ap_s4;

		sq_s6 <= q_s5 * q_s5;
		m5_s6 <= pv1_s5 * cal.p5;
		m2p_s6 <= cal.p2 * pv1_s5;
		temp_s6 <= temp_s5;
		ap_s6 <= ap_s5;

		m6_s7 <= asr(sq_s6, 11) * cal.p6;
		m3_s7 <= cal.p3 * asr(sq_s6, 13);
		m5_s7 <= m5_s6;
		m2p_s7 <= m2p_s6;
		temp_s7 <= temp_s6;
		ap_s7 <= ap_s6;

		v2_s8 <= asr(m6_s7 + (m5_s7 << 1), 2) + (cal.p4 << 16);
		t_s8 <= P1_BIAS + asr(asr(m3_s7, 3) + asr(m2p_s7, 1), 18);
		temp_s8 <= temp_s7;
		ap_s8 <= ap_s7;

		m7_s9 <= t_s8 * cal.p1;
		n_s9 <= (ADC_FULL - {12'd0, ap_s8}) - asr(v2_s8, 12);
		temp_s9 <= temp_s8;

		dv_s10 <= asr(m7_s9, 15);
		pm_s10 <= n_s9 * P_SCALE;
		temp_s10 <= temp_s9;
	end

	// A dividend with its top bit set is divided as is and doubled afterwards.
	assign out_valid = v_q[FRONT_STAGES];
	assign divisor = dv_s10;
	assign dividend = pm_s10[31] ? pm_s10 : (pm_s10 << 1);
	assign side.temp = temp_s10;
	assign side.zero = (dv_s10 == '0);
	assign side.dbl = pm_s10[31];

endmodule

// ----- sv/bpc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module bpc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [31:0]          dividend,
	input  logic [31:0]          divisor,
	input  bpc_pkg::side_t       side_in,
	output logic                 out_valid,
	output logic [31:0]          quotient,
	output bpc_pkg::side_t       side_out
);
	import bpc_pkg::*;

	logic [DIV_W-1:0] v_q;
	logic [DIV_W-1:0] rem_q [DIV_W];
	logic [DIV_W-1:0] quo_q [DIV_W];
	logic [DIV_W-1:0] d_q [DIV_W];
	side_t sd_q [DIV_W];

	for (genvar k = 0; k < DIV_W; k++) begin : g_stage
		logic vi;
		logic [DIV_W-1:0] ri, qi, di;
		side_t si;
		logic [DIV_W:0] tr, diff;
		logic ge;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign ri = '0;
			assign qi = dividend;
			assign di = divisor;
			assign si = side_in;
		end else begin : g_next
			assign vi = v_q[k-1];
			assign ri = rem_q[k-1];
			assign qi = quo_q[k-1];
			assign di = d_q[k-1];
			assign si = sd_q[k-1];
		end

		assign tr = {ri, qi[DIV_W-1]};
		assign diff = tr - {1'b0, di};
		assign ge = (tr >= {1'b0, di});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else begin
				v_q[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k] <= ge ? diff[DIV_W-1:0] : tr[DIV_W-1:0];
			quo_q[k] <= {qi[DIV_W-2:0], ge};
			d_q[k] <= di;
			sd_q[k] <= si;
		end
	end

	assign out_valid = v_q[DIV_W-1];
	assign quotient = quo_q[DIV_W-1];
	assign side_out = sd_q[DIV_W-1];

endmodule

// ----- sv/bpc_back.sv -----
// Pressure correction, millibar conversion and window check.
module bpc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [31:0]          quotient,
	input  bpc_pkg::side_t       side,
	input  bpc_pkg::cal_t        cal,
	input  logic [15:0]          win_lo,
	input  logic [15:0]          win_hi,
	output logic                 out_valid,
	output logic [31:0]          pressure_pa,
	output logic [15:0]          pressure_mbar,
	output logic [15:0]          temp_centi,
	output logic [1:0]           status
);
	import bpc_pkg::*;

	logic [BACK_STAGES:1] v_q;
	side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	logic [31:0] p0_s1, p0_s2, p0_s3, pp_s2, w2m_s2, w2m_s3, m9_s3, pf_s4, pf_s5;
	logic [62:0] prod_s5;
	logic [31:0] pa_s6;
	logic [15:0] mbar_s6, temp_s6;
	logic [1:0] st_s6;
	logic [31:0] p3, corr;
	logic [32:0] xr;
	logic [26:0] mbar_full;
	status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[BACK_STAGES-1:1], in_valid};
		end
	end

	always_comb begin
		p3 = p0_s1 >> 3;
		corr = asr(asr(m9_s3, 12) + asr(w2m_s3, 13) + cal.p7, 4);
		xr = {1'b0, pf_s4} + MBAR_HALF;
		mbar_full = prod_s5[62:RECIP_SHIFT];
		if (sd_s5.zero) begin
			st = ST_ZERO;
		end else if (mbar_full < {11'd0, win_lo} || mbar_full > {11'd0, win_hi}) begin
			st = ST_RANGE;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		p0_s1 <= side.dbl ? (quotient << 1) : quotient;
		sd_s1 <= side;

		pp_s2 <= p3 * p3;
		w2m_s2 <= (p0_s1 >> 2) * cal.p8;
		p0_s2 <= p0_s1;
		sd_s2 <= sd_s1;

		m9_s3 <= cal.p9 * (pp_s2 >> 13);
		w2m_s3 <= w2m_s2;
		p0_s3 <= p0_s2;
		sd_s3 <= sd_s2;

		pf_s4 <= sd_s3.zero ? '0 : (p0_s3 + corr);
		sd_s4 <= sd_s3;

		// (pascal + 50) / 100 as ((pascal + 50) / 4) / 25 by reciprocal.
		prod_s5 <= 63'(xr[32:2]) * 63'(RECIP_25);
		pf_s5 <= pf_s4;
		sd_s5 <= sd_s4;

		pa_s6 <= pf_s5;
		mbar_s6 <= mbar_full[15:0];
		temp_s6 <= sd_s5.temp;
		st_s6 <= st;
	end

	assign out_valid = v_q[BACK_STAGES];
	assign pressure_pa = pa_s6;
	assign pressure_mbar = mbar_s6;
	assign temp_centi = temp_s6;
	assign status = st_s6;

endmodule

// ----- sv/baro_pressure_temp_compensation_top.sv -----
// Top level of the barometer pressure and temperature compensation block.
// One raw pressure/temperature pair is taken on every cycle in which start is
// high and busy is low; busy is high only during and right after reset. Each
// item yields one result, marked by result_valid for a single cycle, after it
// passes the temperature and coefficient arithmetic, the bit-per-stage divider
// and the correction and millibar conversion.
// The receiver cannot stall the output, and none is needed since throughput is
// one item per cycle. Calibration is written through the cfg channel, which is
// always ready, and should be changed only while no item is in flight.
module baro_pressure_temp_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [19:0] adc_press,
	input  logic [19:0] adc_temp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output logic        result_valid,
	output logic [31:0] pressure_pa,
	output logic [15:0] pressure_mbar,
	output logic signed [15:0] temp_centi,
	output logic [1:0]  status
);
	import bpc_pkg::*;

	cal_t cal;
	logic [15:0] win_lo, win_hi;
	logic busy_q, accept;
	logic f_valid, d_valid;
	logic [31:0] dividend, divisor, quotient;
	side_t f_side, d_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign accept = start && !busy_q;
	assign cfg_ready = 1'b1;

	bpc_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cal(cal), .win_lo(win_lo), .win_hi(win_hi)
	);

	bpc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .adc_press(adc_press),
		.adc_temp(adc_temp), .cal(cal), .out_valid(f_valid), .dividend(dividend),
		.divisor(divisor), .side(f_side)
	);

	bpc_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .dividend(dividend),
		.divisor(divisor), .side_in(f_side), .out_valid(d_valid),
		.quotient(quotient), .side_out(d_side)
	);

	bpc_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(d_valid), .quotient(quotient),
		.side(d_side), .cal(cal), .win_lo(win_lo), .win_hi(win_hi),
		.out_valid(result_valid), .pressure_pa(pressure_pa),
		.pressure_mbar(pressure_mbar), .temp_centi(temp_centi), .status(status)
	);

endmodule

// ----- sv/bpc_checker.sv -----
// Port-level checks for the compensation block, bound to the top level.
module bpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [31:0] pressure_pa,
	input logic [15:0] pressure_mbar,
	input logic [1:0]  status
);
	import bpc_pkg::*;

	// Every accepted item yields exactly one result after the fixed latency.
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY result_valid)
		else $error("accepted item produced no result");

	a_result_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_ZERO))
		else $error("undefined status code");

	a_zero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_ZERO) |-> (pressure_pa == '0 && pressure_mbar == '0))
		else $error("zero divisor result carries a pressure");

endmodule

bind baro_pressure_temp_compensation_top bpc_checker u_bpc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .pressure_pa(pressure_pa),
	.pressure_mbar(pressure_mbar), .status(status)
);
